FILE: hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge of clk while rstn is high.
`define CHK_ASSERT(name, clk, rstn, prop) \
    name: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");

// Checks a property on every rising edge of clk, reset included.
`define CHK_ASSERT_ALWAYS(name, clk, prop) \
    name: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

FILE: hw/rtl/wsrh_pkg.sv
`timescale 1ns / 1ps

package wsrh_pkg;

    localparam int FRAC_BITS = 16;
    localparam int AW = 33;
    localparam int DW = AW + FRAC_BITS;
    localparam int RW = 32;
    localparam int SW = DW + 2;
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = PTR_W + 1;
    localparam int ADDR_W = 5;
    localparam logic signed [31:0] FIX_ONE = 32'(64'd1 << FRAC_BITS);

    typedef enum logic [2:0] {
        REG_WRAP_X_LOW,
        REG_WRAP_X_HIGH,
        REG_WRAP_Y_LOW,
        REG_WRAP_Y_HIGH,
        REG_RECT_LEFT,
        REG_RECT_TOP,
        REG_RECT_RIGHT,
        REG_RECT_BOTTOM
    } reg_idx_t;

    typedef struct packed {
        logic signed [31:0] wrap_x_low;
        logic signed [31:0] wrap_x_high;
        logic signed [31:0] wrap_y_low;
        logic signed [31:0] wrap_y_high;
        logic signed [31:0] rect_left;
        logic signed [31:0] rect_top;
        logic signed [31:0] rect_right;
        logic signed [31:0] rect_bottom;
    } cfg_t;

    typedef struct packed {
        logic neg;
        logic [AW-1:0] rem;
        logic [AW-1:0] dvd;
        logic signed [31:0] pt;
        logic signed [31:0] site;
    } fax_t;

    typedef struct packed {
        fax_t x;
        fax_t y;
        logic [30:0] scale;
    } fst_t;

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic [30:0] scale;
    } item_t;

    typedef struct packed {
        logic signed [AW-1:0] dx;
        logic signed [AW-1:0] dy;
        logic [30:0] scale;
    } dst_t;

    typedef struct packed {
        logic neg;
        logic zero;
        logic [RW-1:0] rem;
        logic [DW-1:0] dvd;
    } bax_t;

    typedef struct packed {
        bax_t x;
        bax_t y;
        logic [30:0] scale;
    } bst_t;

    function automatic logic wrap_pass(logic signed [31:0] lo, logic signed [31:0] hi);
        return ((lo == 32'sd0) && (hi == 32'sd0)) || (hi <= lo);
    endfunction

    function automatic logic [AW-1:0] wrap_span(logic signed [31:0] lo,
                                                logic signed [31:0] hi);
        return {hi[31], hi} - {lo[31], lo};
    endfunction

    function automatic fax_t fax_load(logic signed [31:0] pt, logic signed [31:0] site,
                                      logic signed [31:0] lo);
        fax_t f;
        logic [AW-1:0] a;
        a = {site[31], site} - {lo[31], lo};
        f.neg = a[AW-1];
        f.dvd = a[AW-1] ? (~a + 1'b1) : a;
        f.rem = '0;
        f.pt = pt;
        f.site = site;
        return f;
    endfunction

    function automatic fax_t fax_step(fax_t f, logic [AW-1:0] d);
        fax_t g;
        logic [AW-1:0] rs;
        g = f;
        rs = {f.rem[AW-2:0], f.dvd[AW-1]};
        g.rem = (rs >= d) ? (rs - d) : rs;
        g.dvd = {f.dvd[AW-2:0], 1'b0};
        return g;
    endfunction

    function automatic logic signed [31:0] wrap_out(fax_t f, logic signed [31:0] lo,
                                                    logic signed [31:0] hi);
        logic [AW-1:0] d;
        logic [AW-1:0] adj;
        logic [AW-1:0] sum;
        d = wrap_span(lo, hi);
        adj = (f.neg && (f.rem != '0)) ? (d - f.rem) : f.rem;
        sum = {lo[31], lo} + adj;
        return wrap_pass(lo, hi) ? f.site : sum[31:0];
    endfunction

    function automatic bax_t bax_load(logic signed [AW-1:0] diff);
        bax_t b;
        logic [AW-1:0] mag;
        mag = diff[AW-1] ? (~diff + 1'b1) : diff;
        b.neg = diff[AW-1];
        b.zero = (diff == '0);
        b.rem = '0;
        b.dvd = {mag, {FRAC_BITS{1'b0}}};
        return b;
    endfunction

    function automatic bax_t bax_step(bax_t b, logic [30:0] scale);
        bax_t c;
        logic [RW-1:0] rs;
        logic ge;
        c = b;
        rs = {b.rem[RW-2:0], b.dvd[DW-1]};
        ge = (rs >= {1'b0, scale});
        c.rem = ge ? (rs - {1'b0, scale}) : rs;
        c.dvd = {b.dvd[DW-2:0], ge};
        return c;
    endfunction

    function automatic logic signed [DW:0] bax_quot(bax_t b);
        logic [DW:0] q;
        q = {1'b0, b.dvd};
        if (b.zero) begin
            return '0;
        end
        return b.neg ? $signed(~q + 1'b1) : $signed(q);
    endfunction

    function automatic logic signed [SW-1:0] ext32(logic signed [31:0] v);
        return {{(SW-32){v[31]}}, v};
    endfunction

    function automatic logic signed [SW-1:0] extq(logic signed [DW:0] v);
        return {v[DW], v};
    endfunction

    function automatic logic signed [31:0] sat32(logic signed [SW-1:0] v);
        if ((&v[SW-1:31]) || !(|v[SW-1:31])) begin
            return v[31:0];
        end
        return v[SW-1] ? 32'sh80000000 : 32'sh7fffffff;
    endfunction

endpackage

FILE: hw/rtl/wsrh_front.sv
`timescale 1ns / 1ps

module wsrh_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic signed [31:0]   s_point_x,
    input  logic signed [31:0]   s_point_y,
    input  logic signed [31:0]   s_site_x,
    input  logic signed [31:0]   s_site_y,
    input  logic [30:0]          s_site_scale,
    input  wsrh_pkg::cfg_t       cfg,
    output logic                 push_valid,
    input  logic                 push_ready,
    output wsrh_pkg::item_t      push_item
);

    localparam int AW = wsrh_pkg::AW;

    logic [AW:0] vld_reg;
    wsrh_pkg::fst_t st_reg [AW+1];
    logic [AW-1:0] dx;
    logic [AW-1:0] dy;
    logic en;

    assign en = !vld_reg[AW] || push_ready;
    assign s_ready = en;
    assign dx = wsrh_pkg::wrap_span(cfg.wrap_x_low, cfg.wrap_x_high);
    assign dy = wsrh_pkg::wrap_span(cfg.wrap_y_low, cfg.wrap_y_high);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[AW-1:0], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st_reg[0].x <= wsrh_pkg::fax_load(s_point_x, s_site_x, cfg.wrap_x_low);
            st_reg[0].y <= wsrh_pkg::fax_load(s_point_y, s_site_y, cfg.wrap_y_low);
            st_reg[0].scale <= s_site_scale;
            for (int k = 0; k < AW; k++) begin
                st_reg[k+1].x <= wsrh_pkg::fax_step(st_reg[k].x, dx);
                st_reg[k+1].y <= wsrh_pkg::fax_step(st_reg[k].y, dy);
                st_reg[k+1].scale <= st_reg[k].scale;
            end
        end
    end

    always_comb begin
        push_item.px = st_reg[AW].x.pt;
        push_item.py = st_reg[AW].y.pt;
        push_item.cx = wsrh_pkg::wrap_out(st_reg[AW].x, cfg.wrap_x_low, cfg.wrap_x_high);
        push_item.cy = wsrh_pkg::wrap_out(st_reg[AW].y, cfg.wrap_y_low, cfg.wrap_y_high);
        push_item.scale = st_reg[AW].scale;
    end

    assign push_valid = vld_reg[AW];

endmodule

FILE: hw/rtl/wsrh_fifo.sv
`timescale 1ns / 1ps

module wsrh_fifo (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push_valid,
    output logic             push_ready,
    input  wsrh_pkg::item_t  push_item,
    output logic             pop_valid,
    input  logic             pop_ready,
    output wsrh_pkg::item_t  pop_item
);

    localparam int PTR_W = wsrh_pkg::PTR_W;
    localparam int CNT_W = wsrh_pkg::CNT_W;

    wsrh_pkg::item_t mem_reg [wsrh_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic do_push;
    logic do_pop;

    assign push_ready = (cnt_reg != CNT_W'(wsrh_pkg::FIFO_DEPTH));
    assign pop_valid = (cnt_reg != '0);
    assign do_push = push_valid && push_ready;
    assign do_pop = pop_valid && pop_ready;
    assign pop_item = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

FILE: hw/rtl/wsrh_back.sv
`timescale 1ns / 1ps

module wsrh_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 pop_valid,
    output logic                 pop_ready,
    input  wsrh_pkg::item_t      pop_item,
    input  wsrh_pkg::cfg_t       cfg,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_hit,
    output logic signed [31:0]   m_rel_x,
    output logic signed [31:0]   m_rel_y,
    output logic signed [31:0]   m_rect_width,
    output logic signed [31:0]   m_rect_height
);

    localparam int DW = wsrh_pkg::DW;
    localparam int SW = wsrh_pkg::SW;
    localparam int NV = DW + 4;

    logic [NV-1:0] vld_reg;
    wsrh_pkg::dst_t dif_reg;
    wsrh_pkg::bst_t st_reg [DW+1];
    logic signed [DW:0] lx_reg;
    logic signed [DW:0] ly_reg;
    logic hit_reg;
    logic signed [31:0] rel_x_reg;
    logic signed [31:0] rel_y_reg;
    logic signed [31:0] width_reg;
    logic signed [31:0] height_reg;
    logic signed [SW-1:0] lxe;
    logic signed [SW-1:0] lye;
    logic signed [SW-1:0] le;
    logic signed [SW-1:0] te;
    logic signed [SW-1:0] re;
    logic signed [SW-1:0] be;
    logic en;

    assign en = !vld_reg[NV-1] || m_ready;
    assign pop_ready = en;

    assign lxe = wsrh_pkg::extq(lx_reg);
    assign lye = wsrh_pkg::extq(ly_reg);
    assign le = wsrh_pkg::ext32(cfg.rect_left);
    assign te = wsrh_pkg::ext32(cfg.rect_top);
    assign re = wsrh_pkg::ext32(cfg.rect_right);
    assign be = wsrh_pkg::ext32(cfg.rect_bottom);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NV-2:0], pop_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dif_reg.dx <= {pop_item.px[31], pop_item.px} - {pop_item.cx[31], pop_item.cx};
            dif_reg.dy <= {pop_item.py[31], pop_item.py} - {pop_item.cy[31], pop_item.cy};
            dif_reg.scale <= pop_item.scale;
            st_reg[0].x <= wsrh_pkg::bax_load(dif_reg.dx);
            st_reg[0].y <= wsrh_pkg::bax_load(dif_reg.dy);
            st_reg[0].scale <= dif_reg.scale;
            for (int k = 0; k < DW; k++) begin
                st_reg[k+1].x <= wsrh_pkg::bax_step(st_reg[k].x, st_reg[k].scale);
                st_reg[k+1].y <= wsrh_pkg::bax_step(st_reg[k].y, st_reg[k].scale);
                st_reg[k+1].scale <= st_reg[k].scale;
            end
            lx_reg <= wsrh_pkg::bax_quot(st_reg[DW].x);
            ly_reg <= wsrh_pkg::bax_quot(st_reg[DW].y);
            hit_reg <= (lxe >= le) && (lxe <= re) && (lye >= te) && (lye <= be);
            rel_x_reg <= wsrh_pkg::sat32(lxe - le);
            rel_y_reg <= wsrh_pkg::sat32(lye - te);
            width_reg <= wsrh_pkg::sat32(re - le);
            height_reg <= wsrh_pkg::sat32(be - te);
        end
    end

    assign m_valid = vld_reg[NV-1];
    assign m_hit = hit_reg;
    assign m_rel_x = rel_x_reg;
    assign m_rel_y = rel_y_reg;
    assign m_rect_width = width_reg;
    assign m_rect_height = height_reg;

endmodule

FILE: hw/rtl/wrapped_scaled_rect_hit_test.sv
`timescale 1ns / 1ps

// Channel   Ports                                          Moves
// input     s_valid/s_ready, s_point_*, s_site_*           one point and site per transfer
// result    m_valid/m_ready, m_hit, m_rel_*, m_rect_*      one result per transfer
// config    psel/penable/pwrite/paddr/pwdata/prdata/pready  one register per write
//
// One transfer is taken per cycle while s_ready is high.
// The datapath is the 33-step wrap remainder pipeline and the 33 + FRAC_BITS step
// divider pipeline, with a four-entry queue between them.
// Reset is synchronous and active low; it clears all valid flags and loads register defaults.
// A stall on the result side freezes the back pipeline, and the input stalls once the
// four-entry queue is full and the front pipeline holds a transfer at its end.

module wrapped_scaled_rect_hit_test (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [31:0]                  s_point_x,
    input  logic signed [31:0]                  s_point_y,
    input  logic signed [31:0]                  s_site_x,
    input  logic signed [31:0]                  s_site_y,
    input  logic [30:0]                         s_site_scale,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_hit,
    output logic signed [31:0]                  m_rel_x,
    output logic signed [31:0]                  m_rel_y,
    output logic signed [31:0]                  m_rect_width,
    output logic signed [31:0]                  m_rect_height,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [wsrh_pkg::ADDR_W-1:0]         paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    wsrh_pkg::cfg_t cfg_reg;
    wsrh_pkg::reg_idx_t idx;
    wsrh_pkg::item_t push_item;
    wsrh_pkg::item_t pop_item;
    logic push_valid;
    logic push_ready;
    logic pop_valid;
    logic pop_ready;

    assign pready = 1'b1;
    assign idx = wsrh_pkg::reg_idx_t'(paddr[wsrh_pkg::ADDR_W-1:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= {192'd0, wsrh_pkg::FIX_ONE, wsrh_pkg::FIX_ONE};
        end else if (psel && penable && pwrite) begin
            unique case (idx)
                wsrh_pkg::REG_WRAP_X_LOW:  cfg_reg.wrap_x_low <= pwdata;
                wsrh_pkg::REG_WRAP_X_HIGH: cfg_reg.wrap_x_high <= pwdata;
                wsrh_pkg::REG_WRAP_Y_LOW:  cfg_reg.wrap_y_low <= pwdata;
                wsrh_pkg::REG_WRAP_Y_HIGH: cfg_reg.wrap_y_high <= pwdata;
                wsrh_pkg::REG_RECT_LEFT:   cfg_reg.rect_left <= pwdata;
                wsrh_pkg::REG_RECT_TOP:    cfg_reg.rect_top <= pwdata;
                wsrh_pkg::REG_RECT_RIGHT:  cfg_reg.rect_right <= pwdata;
                wsrh_pkg::REG_RECT_BOTTOM: cfg_reg.rect_bottom <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            wsrh_pkg::REG_WRAP_X_LOW:  prdata = cfg_reg.wrap_x_low;
            wsrh_pkg::REG_WRAP_X_HIGH: prdata = cfg_reg.wrap_x_high;
            wsrh_pkg::REG_WRAP_Y_LOW:  prdata = cfg_reg.wrap_y_low;
            wsrh_pkg::REG_WRAP_Y_HIGH: prdata = cfg_reg.wrap_y_high;
            wsrh_pkg::REG_RECT_LEFT:   prdata = cfg_reg.rect_left;
            wsrh_pkg::REG_RECT_TOP:    prdata = cfg_reg.rect_top;
            wsrh_pkg::REG_RECT_RIGHT:  prdata = cfg_reg.rect_right;
            wsrh_pkg::REG_RECT_BOTTOM: prdata = cfg_reg.rect_bottom;
            default:                   prdata = '0;
        endcase
    end

    wsrh_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_point_x    (s_point_x),
        .s_point_y    (s_point_y),
        .s_site_x     (s_site_x),
        .s_site_y     (s_site_y),
        .s_site_scale (s_site_scale),
        .cfg          (cfg_reg),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .push_item    (push_item)
    );

    wsrh_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    wsrh_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .pop_valid     (pop_valid),
        .pop_ready     (pop_ready),
        .pop_item      (pop_item),
        .cfg           (cfg_reg),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_hit         (m_hit),
        .m_rel_x       (m_rel_x),
        .m_rel_y       (m_rel_y),
        .m_rect_width  (m_rect_width),
        .m_rect_height (m_rect_height)
    );

endmodule

FILE: hw/rtl/wsrh_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module wsrh_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic                         m_hit,
    input logic signed [31:0]           m_rel_x,
    input logic signed [31:0]           m_rel_y,
    input logic signed [31:0]           m_rect_width,
    input logic signed [31:0]           m_rect_height,
    input logic                         pready
);

    `CHK_ASSERT_ALWAYS(a_reset_clears_out, aclk, !aresetn |=> !m_valid)
    `CHK_ASSERT(a_out_holds, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_rel_x))
    `CHK_ASSERT(a_hit_rel_x, aclk, aresetn, m_valid && m_hit |-> !m_rel_x[31] && m_rel_x <= m_rect_width)
    `CHK_ASSERT(a_hit_rel_y, aclk, aresetn, m_valid && m_hit |-> !m_rel_y[31] && m_rel_y <= m_rect_height)
    `CHK_ASSERT_ALWAYS(a_pready_high, aclk, pready)

endmodule

bind wrapped_scaled_rect_hit_test wsrh_checker u_wsrh_checker (.*);

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int FB = wsrh_pkg::FRAC_BITS;
    localparam longint BIG = 64'sd1 <<< 62;

    typedef struct {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic [30:0] sc;
    } point_item_t;

    typedef struct {
        logic hit;
        logic signed [31:0] rel_x;
        logic signed [31:0] rel_y;
        logic signed [31:0] width;
        logic signed [31:0] height;
    } hit_result_t;

    typedef struct {
        point_item_t it;
        bit known;
        hit_result_t res;
    } stim_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [31:0] s_point_x = '0, s_point_y = '0, s_site_x = '0, s_site_y = '0;
    logic [30:0] s_site_scale = 31'd1;
    logic m_valid;
    logic m_ready = 1'b0;
    logic m_hit;
    logic signed [31:0] m_rel_x, m_rel_y, m_rect_width, m_rect_height;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [wsrh_pkg::ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    wrapped_scaled_rect_hit_test DUT (.*);

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    longint hit_regs [8];
    hit_result_t expected_hits [$];
    int error_count = 0;
    bit rx_hold = 1'b0;
    bit stim_done = 1'b0;

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint wrap_site(longint v, longint lo, longint hi);
        longint d, t;
        if ((lo == 0 && hi == 0) || hi <= lo) return v;
        d = hi - lo;
        t = (v - lo) % d;
        if (t < 0) t += d;
        return lo + t;
    endfunction

    function automatic longint scaled_local(longint diff, longint sc);
        longint num;
        num = diff * (64'sd1 <<< FB);
        if (sc == 0) return num > 0 ? BIG : (num < 0 ? -BIG : 0);
        return num / sc;
    endfunction

    function automatic hit_result_t predict_hit(point_item_t it);
        hit_result_t r;
        longint l, t, rr, b, lx, ly;
        l = hit_regs[wsrh_pkg::REG_RECT_LEFT];
        t = hit_regs[wsrh_pkg::REG_RECT_TOP];
        rr = hit_regs[wsrh_pkg::REG_RECT_RIGHT];
        b = hit_regs[wsrh_pkg::REG_RECT_BOTTOM];
        lx = scaled_local(longint'(it.px) - wrap_site(it.sx, hit_regs[wsrh_pkg::REG_WRAP_X_LOW],
                          hit_regs[wsrh_pkg::REG_WRAP_X_HIGH]), longint'({1'b0, it.sc}));
        ly = scaled_local(longint'(it.py) - wrap_site(it.sy, hit_regs[wsrh_pkg::REG_WRAP_Y_LOW],
                          hit_regs[wsrh_pkg::REG_WRAP_Y_HIGH]), longint'({1'b0, it.sc}));
        r.hit = (lx >= l) && (lx <= rr) && (ly >= t) && (ly <= b);
        r.rel_x = 32'(clamp32(lx - l));
        r.rel_y = 32'(clamp32(ly - t));
        r.width = 32'(clamp32(rr - l));
        r.height = 32'(clamp32(b - t));
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        error_count++;
    endtask

    task automatic write_reg(wsrh_pkg::reg_idx_t idx, logic signed [31:0] val);
        @(negedge aclk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= wsrh_pkg::ADDR_W'(4 * int'(idx));
        pwdata <= val;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        hit_regs[idx] = val;
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic send_point(point_item_t it, bit known, hit_result_t res);
        int gap;
        gap = $urandom_range(0, 7);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_point_x <= it.px;
        s_point_y <= it.py;
        s_site_x <= it.sx;
        s_site_y <= it.sy;
        s_site_scale <= it.sc;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_hits.push_back(known ? res : predict_hit(it));
        @(negedge aclk);
    endtask

    task automatic idle_input();
        s_valid <= 1'b0;
    endtask

    task automatic drain_and_settle();
        while (expected_hits.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    function automatic point_item_t rand_point(int mode);
        point_item_t it;
        it.px = $urandom();
        it.py = $urandom();
        it.sx = $urandom();
        it.sy = $urandom();
        it.sc = 31'($urandom());
        if (mode == 0) begin
            it.px = $signed($urandom_range(0, 8 << 16)) - (4 << 16);
            it.py = $signed($urandom_range(0, 8 << 16)) - (4 << 16);
            it.sx = $signed($urandom_range(0, 8 << 16)) - (4 << 16);
            it.sy = $signed($urandom_range(0, 8 << 16)) - (4 << 16);
            it.sc = 31'($urandom_range(1 << 14, 4 << 16));
        end else if (mode == 1) begin
            it.sc = 31'($urandom_range(0, 3));
        end
        return it;
    endfunction

    always @(posedge aclk) begin
        hit_result_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_hits.size() == 0) begin
                report_mismatch("unexpected result transfer", 1, 0);
            end else begin
                e = expected_hits.pop_front();
                if (m_hit !== e.hit) report_mismatch("hit", m_hit, e.hit);
                if (m_rel_x !== e.rel_x) report_mismatch("rel_x", m_rel_x, e.rel_x);
                if (m_rel_y !== e.rel_y) report_mismatch("rel_y", m_rel_y, e.rel_y);
                if (m_rect_width !== e.width)
                    report_mismatch("rect_width", m_rect_width, e.width);
                if (m_rect_height !== e.height)
                    report_mismatch("rect_height", m_rect_height, e.height);
            end
        end
    end

    initial begin
        int cnt;
        cnt = 0;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (rx_hold) begin
                m_ready <= 1'b0;
            end else if (cnt > 0) begin
                m_ready <= 1'b0;
                cnt--;
            end else begin
                m_ready <= 1'b1;
                if ($urandom_range(0, 1)) cnt = $urandom_range(0, 7);
            end
        end
    end

    initial begin
        #3000000;
        $display("TB_ERROR");
        $finish;
    end

    stim_row_t directed [$];

    function automatic stim_row_t row(longint px, longint py, longint sx, longint sy,
                                      longint sc, bit known = 0, bit h = 0,
                                      longint rx = 0, longint ry = 0);
        stim_row_t r;
        r.it.px = 32'(px);
        r.it.py = 32'(py);
        r.it.sx = 32'(sx);
        r.it.sy = 32'(sy);
        r.it.sc = 31'(sc);
        r.known = known;
        r.res.hit = h;
        r.res.rel_x = 32'(rx);
        r.res.rel_y = 32'(ry);
        r.res.width = 32'sd65536;
        r.res.height = 32'sd65536;
        return r;
    endfunction

    initial begin
        point_item_t it;
        hit_result_t none;
        int mode;
        logic signed [31:0] lo, hi;
        none = '{default: 0};
        for (int i = 0; i < 8; i++) hit_regs[i] = 0;
        hit_regs[wsrh_pkg::REG_RECT_RIGHT] = 65536;
        hit_regs[wsrh_pkg::REG_RECT_BOTTOM] = 65536;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        directed.push_back(row(0, 0, 0, 0, 65536, 1, 1, 0, 0));
        directed.push_back(row(65536, 65536, 0, 0, 65536, 1, 1, 65536, 65536));
        directed.push_back(row(65537, 0, 0, 0, 65536, 1, 0, 65537, 0));
        directed.push_back(row(-1, 0, 0, 0, 65536, 1, 0, -1, 0));
        directed.push_back(row(32'h7fffffff, 0, 0, 0, 1, 1, 0, 32'h7fffffff, 0));
        directed.push_back(row(32'h80000000, 0, 0, 0, 1, 1, 0, -64'sd2147483648, 0));
        directed.push_back(row(0, 0, 0, 0, 0, 1, 1, 0, 0));
        directed.push_back(row(5, -5, 0, 0, 0));
        directed.push_back(row(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff, 1));
        directed.push_back(row(32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
                               31'h7fffffff));
        directed.push_back(row(100, 200, 300, 400, 31'h7fffffff));
        directed.push_back(row(3 << 16, 2 << 16, 1 << 16, 1 << 16, 2 << 16));
        foreach (directed[i]) send_point(directed[i].it, directed[i].known, directed[i].res);
        idle_input();
        drain_and_settle();

        write_reg(wsrh_pkg::REG_WRAP_X_LOW, -(2 << 16));
        write_reg(wsrh_pkg::REG_WRAP_X_HIGH, 3 << 16);
        write_reg(wsrh_pkg::REG_WRAP_Y_LOW, 32'h80000000);
        write_reg(wsrh_pkg::REG_WRAP_Y_HIGH, 32'h7fffffff);
        write_reg(wsrh_pkg::REG_RECT_LEFT, -(1 << 16));
        write_reg(wsrh_pkg::REG_RECT_TOP, 32'h80000000);
        write_reg(wsrh_pkg::REG_RECT_RIGHT, 32'h7fffffff);
        write_reg(wsrh_pkg::REG_RECT_BOTTOM, 1 << 15);
        for (int i = 0; i < 8; i++) begin
            it = rand_point(i % 3);
            if (i == 0) it.sx = 32'h80000000;
            if (i == 1) it.sx = 32'h7fffffff;
            send_point(it, 0, none);
        end
        idle_input();
        drain_and_settle();

        for (int ph = 0; ph < 6; ph++) begin
            for (int r = 0; r < 4; r++) begin
                lo = $urandom();
                hi = $urandom();
                if (ph == 1) begin
                    lo = 0;
                    hi = 0;
                end else if (ph == 2) begin
                    hi = lo;
                end else if (ph >= 3) begin
                    lo = $signed($urandom_range(0, 16 << 16)) - (8 << 16);
                    hi = lo + $signed($urandom_range(1, 8 << 16));
                end
                write_reg(wsrh_pkg::reg_idx_t'(r), lo);
                if (ph == 5) begin
                    lo = $signed($urandom_range(0, 4 << 16)) - (2 << 16);
                    hi = lo + $signed($urandom_range(0, 4 << 16));
                end
                write_reg(wsrh_pkg::reg_idx_t'(r + 4), (ph == 5) ? lo : hi);
            end
            if (ph == 4) rx_hold = 1'b1;
            fork
                begin
                    if (ph == 4) begin
                        repeat (400) @(posedge aclk);
                        rx_hold = 1'b0;
                    end
                end
                begin
                    for (int i = 0; i < 90; i++) begin
                        mode = $urandom_range(0, 5);
                        it = rand_point(mode < 3 ? 0 : (mode == 3 ? 1 : 2));
                        send_point(it, 0, none);
                    end
                    idle_input();
                end
            join
            drain_and_settle();
        end

        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/wsrh_pkg.sv
hw/rtl/wsrh_front.sv
hw/rtl/wsrh_fifo.sv
hw/rtl/wsrh_back.sv
hw/rtl/wrapped_scaled_rect_hit_test.sv
hw/rtl/wsrh_checker.sv
tb/tb_top.sv
